@@ rtl/core/key_value_directory_table_unit_assert.svh @@
// Assertion macros for the key/value directory table.
// Used by key_value_directory_table_unit; needs clk and rst_n in the calling scope.
`ifndef KEY_VALUE_DIRECTORY_TABLE_UNIT_ASSERT_SVH
`define KEY_VALUE_DIRECTORY_TABLE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KVDT_ASSERT_IMP(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("key/value table: same-cycle check failed");
`define KVDT_ASSERT_NXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("key/value table: next-cycle check failed");
`else
`define KVDT_ASSERT_IMP(lbl, cond, conseq)
`define KVDT_ASSERT_NXT(lbl, cond, conseq)
`endif
`endif

@@ rtl/core/kvdt_pkg.sv @@
// Shared types and constants for the key/value directory table.
// No dependencies; used by key_value_directory_table_unit.
package kvdt_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BYTES = 8;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int VAL_W = 8 * VALUE_BYTES;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Field widths on the stream ports.
  localparam int ACTION_W   = 2;
  localparam int FIELD_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - FIELD_W;

  localparam int IN_KEY_LSB = ACTION_W;
  localparam int IN_VAL_LSB = ACTION_W + FIELD_W;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

endpackage

@@ rtl/core/key_value_directory_table_unit.sv @@
// Key/value directory table: sixteen name/value slots held in two synchronous RAMs.
// Requests are handled one at a time: a new word is taken only once the previous one has been
// executed and the sequencer is back in idle. An empty name skips the RAM scan.
// Reset (synchronous, rst_n low) clears the slot valid marks, the sequencer and the output
// valid flag; the name and value RAMs are not cleared and are only read behind a set valid mark.
// Depends on kvdt_pkg and key_value_directory_table_unit_assert.svh.
`include "key_value_directory_table_unit_assert.svh"

module key_value_directory_table_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata, lowest bit up: action[1:0], key[65:2], entry_value[129:66], zero padding.
  input  logic [kvdt_pkg::IN_DATA_W-1:0]   in_tdata,
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata, lowest bit up: status[1:0], read_value[65:2], zero padding.
  output logic [kvdt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // The block works on one request at a time. A request is taken in the idle
  // state, the RAMs are then swept one entry per cycle while a registered compare
  // stage, working on each entry in the cycle after its address is issued, looks for
  // the matching name and the lowest free slot, and a final execute cycle writes back
  // and loads the output register. Because every write lands before the next sweep
  // starts, reads and writes of the same entry never overlap and no forwarding is needed.

  kvdt_pkg::state_t state_r, state_nxt;

  // Captured request.
  kvdt_pkg::action_t          act_r;
  logic [kvdt_pkg::KEY_W-1:0] key_r;
  logic [kvdt_pkg::VAL_W-1:0] val_r;
  logic                       empty_r;

  // Sweep counter and compare stage.
  logic [kvdt_pkg::CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic [kvdt_pkg::IDX_W-1:0] cmp_idx_r;
  logic [kvdt_pkg::KEY_W-1:0] name_rd_r;
  logic [kvdt_pkg::VAL_W-1:0] val_rd_r;

  // Sweep results.
  logic                       hit_r, hit_nxt;
  logic [kvdt_pkg::IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [kvdt_pkg::VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic                       free_r, free_nxt;
  logic [kvdt_pkg::IDX_W-1:0] free_idx_r, free_idx_nxt;

  // Slot valid marks, in flip-flops so that reset clears them at once.
  logic [kvdt_pkg::ENTRIES-1:0] used_r;

  // Output register.
  logic                       out_tvalid_r;
  kvdt_pkg::status_t          out_status_r;
  logic [kvdt_pkg::VAL_W-1:0] out_value_r;

  // The two RAMs.
  logic [kvdt_pkg::KEY_W-1:0] name_mem [kvdt_pkg::ENTRIES];
  logic [kvdt_pkg::VAL_W-1:0] value_mem [kvdt_pkg::ENTRIES];

  logic [kvdt_pkg::FIELD_W-1:0] in_key;
  logic [kvdt_pkg::FIELD_W-1:0] in_value;
  logic                         in_fire;
  logic                         exec_fire;
  logic [kvdt_pkg::IDX_W-1:0]   rd_addr;

  // Decoded effect of the execute cycle.
  kvdt_pkg::status_t          res_status;
  logic [kvdt_pkg::VAL_W-1:0] res_value;
  logic                       name_we;
  logic                       value_we;
  logic [kvdt_pkg::IDX_W-1:0] wr_idx;
  logic                       set_used;
  logic                       clr_used;

  assign in_key   = in_tdata[kvdt_pkg::IN_KEY_LSB +: kvdt_pkg::FIELD_W];
  assign in_value = in_tdata[kvdt_pkg::IN_VAL_LSB +: kvdt_pkg::FIELD_W];
  assign in_fire  = in_tvalid && in_tready;
  // The execute cycle waits only if an earlier word still sits in the output register.
  assign exec_fire = (state_r == kvdt_pkg::S_EXEC) && (!out_tvalid_r || out_tready);
  assign rd_addr   = scan_cnt_r[kvdt_pkg::IDX_W-1:0];

  // ------------------------------------------------------------------
  // Sequencer: next state.
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kvdt_pkg::S_IDLE: begin
        if (in_fire) begin
          // An empty name skips the sweep altogether.
          if (in_key[kvdt_pkg::KEY_W-1:0] == '0) begin
            state_nxt = kvdt_pkg::S_EXEC;
          end else begin
            state_nxt = kvdt_pkg::S_SCAN;
          end
        end
      end
      kvdt_pkg::S_SCAN: begin
        // Once every address is issued, the last compare completes at this edge.
        if (scan_cnt_r == kvdt_pkg::CNT_W'(kvdt_pkg::ENTRIES)) begin
          state_nxt = kvdt_pkg::S_EXEC;
        end
      end
      kvdt_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_nxt = kvdt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kvdt_pkg::S_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: outputs (handshake, sweep counter, compare issue).
  // ------------------------------------------------------------------
  always_comb begin
    in_tready    = 1'b0;
    scan_cnt_nxt = scan_cnt_r;
    cmp_vld_nxt  = 1'b0;
    case (state_r)
      kvdt_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        scan_cnt_nxt = '0;
      end
      kvdt_pkg::S_SCAN: begin
        if (scan_cnt_r != kvdt_pkg::CNT_W'(kvdt_pkg::ENTRIES)) begin
          scan_cnt_nxt = scan_cnt_r + kvdt_pkg::CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
        end
      end
      kvdt_pkg::S_EXEC: begin
        scan_cnt_nxt = scan_cnt_r;
      end
      default: begin
        scan_cnt_nxt = '0;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Compare stage: the first valid slot holding the name, and the lowest
  // slot without a valid mark. A free slot is never compared, so its RAM
  // contents do not matter.
  // ------------------------------------------------------------------
  always_comb begin
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_val_nxt  = hit_val_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    if (in_fire) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (cmp_vld_r) begin
      if (used_r[cmp_idx_r]) begin
        if (!hit_r && (name_rd_r == key_r)) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_val_nxt = val_rd_r;
        end
      end else if (!free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  // ------------------------------------------------------------------
  // Execute decode: status, read value and write-back for the request.
  // ------------------------------------------------------------------
  always_comb begin
    res_status = kvdt_pkg::STS_INVALID;
    res_value  = '0;
    name_we    = 1'b0;
    value_we   = 1'b0;
    wr_idx     = hit_idx_r;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    if (!empty_r) begin
      case (act_r)
        kvdt_pkg::ACT_ADD: begin
          wr_idx = free_idx_r;
          if (hit_r) begin
            res_status = kvdt_pkg::STS_INVALID;
          end else if (!free_r) begin
            res_status = kvdt_pkg::STS_FULL;
          end else begin
            res_status = kvdt_pkg::STS_OK;
            name_we    = 1'b1;
            value_we   = 1'b1;
            set_used   = 1'b1;
          end
        end
        kvdt_pkg::ACT_GET: begin
          if (hit_r) begin
            res_status = kvdt_pkg::STS_OK;
            res_value  = hit_val_r;
          end
        end
        kvdt_pkg::ACT_UPDATE: begin
          if (hit_r) begin
            res_status = kvdt_pkg::STS_OK;
            value_we   = 1'b1;
          end
        end
        kvdt_pkg::ACT_DELETE: begin
          if (hit_r) begin
            res_status = kvdt_pkg::STS_OK;
            clr_used   = 1'b1;
          end
        end
        default: begin
          res_status = kvdt_pkg::STS_INVALID;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kvdt_pkg::S_IDLE;
      scan_cnt_r   <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      used_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      hit_r      <= hit_nxt;
      free_r     <= free_nxt;
      if (exec_fire && set_used) begin
        used_r[wr_idx] <= 1'b1;
      end
      if (exec_fire && clr_used) begin
        used_r[wr_idx] <= 1'b0;
      end
      if (exec_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r   <= kvdt_pkg::action_t'(in_tdata[kvdt_pkg::ACTION_W-1:0]);
      key_r   <= in_key[kvdt_pkg::KEY_W-1:0];
      val_r   <= in_value[kvdt_pkg::VAL_W-1:0];
      empty_r <= (in_key[kvdt_pkg::KEY_W-1:0] == '0);
    end
    cmp_idx_r  <= rd_addr;
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    free_idx_r <= free_idx_nxt;
    if (exec_fire) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

  // ------------------------------------------------------------------
  // RAMs: one write port, one registered read port each.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (exec_fire && name_we) begin
      name_mem[wr_idx] <= key_r;
    end
    name_rd_r <= name_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (exec_fire && value_we) begin
      value_mem[wr_idx] <= val_r;
    end
    val_rd_r <= value_mem[rd_addr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{kvdt_pkg::OUT_PAD_W{1'b0}},
                       kvdt_pkg::FIELD_W'(out_value_r),
                       out_status_r};

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  // An accepted word always leaves the idle state.
  `KVDT_ASSERT_NXT(a_accept_leaves_idle, in_fire, state_r != kvdt_pkg::S_IDLE)
  // A new result only appears after an execute cycle.
  `KVDT_ASSERT_IMP(a_result_from_exec, $rose(out_tvalid_r), $past(state_r == kvdt_pkg::S_EXEC))
  // The sweep counter never runs past the table.
  `KVDT_ASSERT_IMP(a_scan_in_range, state_r == kvdt_pkg::S_SCAN,
                   scan_cnt_r <= kvdt_pkg::CNT_W'(kvdt_pkg::ENTRIES))
  // The valid marks change by at most one slot per request.
  `KVDT_ASSERT_NXT(a_one_slot_change, 1'b1,
                   $countones(used_r ^ $past(used_r)) <= 1)

endmodule
